FILE: src/dqvs_pkg.sv
// Shared types and constants for the deque with value search.
package dqvs_pkg;

  // Default sizes of the queue.
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed payload widths.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STATUS_W = 2;

  // Operation codes carried by an input item.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_TAIL = 3'd0,
    OP_PUSH_HEAD = 3'd1,
    OP_POP_TAIL  = 3'd2,
    OP_POP_HEAD  = 3'd3,
    OP_SEARCH    = 3'd4,
    OP_CLEAR     = 3'd5
  } op_e;

  // Status codes returned with each result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,        // keep the stored word
    CELL_LOAD_TAIL,   // the cell at the tail slot takes the pushed word
    CELL_SHIFT_RIGHT, // every cell takes its head-side neighbor (push at head)
    CELL_SHIFT_LEFT   // every cell takes its tail-side neighbor, last live cell wraps
  } cell_cmd_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_DONE
  } state_e;

endpackage

FILE: src/dqvs_if.sv
// Handshake channels for input items and result items.
interface dqvs_item_if #(
  parameter int unsigned DATA_WIDTH = dqvs_pkg::DATA_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic [dqvs_pkg::OP_W-1:0]   operation;
  logic [DATA_WIDTH-1:0]       value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dqvs_result_if #(
  parameter int unsigned DEPTH = dqvs_pkg::DEPTH_DEF
);
  localparam int unsigned POS_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [dqvs_pkg::STATUS_W-1:0] status;
  logic [POS_W-1:0]              position;
  logic [OCC_W-1:0]              occupancy;

  modport source (output valid, output status, output position, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input position, input occupancy,
                  output ready);
endinterface

FILE: src/dqvs_cell.sv
// One storage cell of the queue chain: holds one word and trades it with its neighbors.
module dqvs_cell #(
  parameter int unsigned DATA_WIDTH = dqvs_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CNT_W      = 11,
  parameter int unsigned IDX        = 0
) (
  input  logic                clk_i,
  input  dqvs_pkg::cell_cmd_e cmd_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [DATA_WIDTH-1:0] word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  input  logic [DATA_WIDTH-1:0] head_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  // Select what this cell holds after the current cycle.
  always_comb begin
    data_d = data_q;
    case (cmd_i)
      dqvs_pkg::CELL_HOLD: data_d = data_q;
      dqvs_pkg::CELL_LOAD_TAIL: begin
        if (count_i == IDX_C) data_d = word_i;
      end
      dqvs_pkg::CELL_SHIFT_RIGHT: data_d = left_i;
      dqvs_pkg::CELL_SHIFT_LEFT: begin
        // The last live cell takes the head word so that a full pass rotates the queue.
        data_d = (count_i == NEXT_C) ? head_i : right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/dqvs_ctrl.sv
// Sequencer: takes operations, drives the cell chain and returns one result per item.
module dqvs_ctrl #(
  parameter int unsigned DEPTH      = dqvs_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dqvs_pkg::DATA_WIDTH_DEF,
  parameter int unsigned CNT_W      = $clog2(DEPTH + 1),
  parameter int unsigned POS_W      = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dqvs_item_if.sink             item_i,
  dqvs_result_if.source         result_o,
  input  logic [DATA_WIDTH-1:0] head_data_i,
  output logic [DATA_WIDTH-1:0] word_o,
  output logic [CNT_W-1:0]      count_o,
  output dqvs_pkg::cell_cmd_e   cmd_o
);

  localparam logic [CNT_W-1:0] FULL_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  dqvs_pkg::state_e state_d, state_q;
  dqvs_pkg::op_e    op_q;
  logic [DATA_WIDTH-1:0] word_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] step_d, step_q;
  logic             found_d, found_q;
  logic [POS_W-1:0] match_d, match_q;

  logic                   out_valid_d, out_valid_q;
  logic [dqvs_pkg::STATUS_W-1:0] out_status_q;
  logic [POS_W-1:0]       out_pos_q;
  logic [CNT_W-1:0]       out_occ_q;

  logic             out_free;
  logic             full, empty, last_step;
  logic             res_load;
  dqvs_pkg::status_e res_status;
  logic [POS_W-1:0] res_pos;

  assign out_free  = !out_valid_q || result_o.ready;
  assign full      = (count_q == FULL_C);
  assign empty     = (count_q == '0);
  assign last_step = (step_q == (count_q - ONE_C));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqvs_pkg::S_IDLE: begin
        if (item_i.valid) state_d = dqvs_pkg::S_EXEC;
      end
      dqvs_pkg::S_EXEC: begin
        if (op_q == dqvs_pkg::OP_SEARCH) begin
          state_d = empty ? dqvs_pkg::S_DONE : dqvs_pkg::S_SEARCH;
        end else if (out_free) begin
          state_d = dqvs_pkg::S_IDLE;
        end
      end
      dqvs_pkg::S_SEARCH: begin
        if (last_step) state_d = dqvs_pkg::S_DONE;
      end
      dqvs_pkg::S_DONE: begin
        if (out_free) state_d = dqvs_pkg::S_IDLE;
      end
      default: state_d = dqvs_pkg::S_IDLE;
    endcase
  end

  // Cell commands, occupancy update, search tracking and the result to register.
  always_comb begin
    cmd_o      = dqvs_pkg::CELL_HOLD;
    count_d    = count_q;
    step_d     = step_q;
    found_d    = found_q;
    match_d    = match_q;
    res_load   = 1'b0;
    res_status = dqvs_pkg::ST_OK;
    res_pos    = '0;
    case (state_q)
      dqvs_pkg::S_EXEC: begin
        step_d  = '0;
        found_d = 1'b0;
        match_d = '0;
        if (op_q != dqvs_pkg::OP_SEARCH && out_free) begin
          res_load = 1'b1;
          case (op_q)
            dqvs_pkg::OP_PUSH_TAIL: begin
              if (full) begin
                res_status = dqvs_pkg::ST_FULL;
              end else begin
                cmd_o   = dqvs_pkg::CELL_LOAD_TAIL;
                count_d = count_q + ONE_C;
              end
            end
            dqvs_pkg::OP_PUSH_HEAD: begin
              if (full) begin
                res_status = dqvs_pkg::ST_FULL;
              end else begin
                cmd_o   = dqvs_pkg::CELL_SHIFT_RIGHT;
                count_d = count_q + ONE_C;
              end
            end
            dqvs_pkg::OP_POP_TAIL: begin
              if (empty) res_status = dqvs_pkg::ST_EMPTY;
              else       count_d    = count_q - ONE_C;
            end
            dqvs_pkg::OP_POP_HEAD: begin
              if (empty) begin
                res_status = dqvs_pkg::ST_EMPTY;
              end else begin
                cmd_o   = dqvs_pkg::CELL_SHIFT_LEFT;
                count_d = count_q - ONE_C;
              end
            end
            dqvs_pkg::OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      dqvs_pkg::S_SEARCH: begin
        // Rotate the live entries past the head cell once, comparing each in turn.
        cmd_o  = dqvs_pkg::CELL_SHIFT_LEFT;
        step_d = step_q + ONE_C;
        if (!found_q && head_data_i == word_q) begin
          found_d = 1'b1;
          match_d = step_q[POS_W-1:0];
        end
      end
      dqvs_pkg::S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_status = found_q ? dqvs_pkg::ST_OK : dqvs_pkg::ST_NOTFOUND;
          res_pos    = found_q ? match_q : '0;
        end
      end
      default: ;
    endcase
  end

  // The output register frees when its transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load)             out_valid_d = 1'b1;
    else if (result_o.ready)  out_valid_d = 1'b0;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqvs_pkg::S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers for the accepted item, the match and the result.
  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (item_i.valid && item_i.ready) begin
      op_q   <= dqvs_pkg::op_e'(item_i.operation);
      word_q <= item_i.value;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos;
      out_occ_q    <= count_d;
    end
  end

  assign item_i.ready       = (state_q == dqvs_pkg::S_IDLE);
  assign result_o.valid     = out_valid_q;
  assign result_o.status    = out_status_q;
  assign result_o.position  = out_pos_q;
  assign result_o.occupancy = out_occ_q;

  assign word_o  = word_q;
  assign count_o = count_q;

endmodule

FILE: src/deque_with_value_search_core.sv
// Top level of the deque with value search: sequencer plus a chain of storage cells.
//
// A bounded double-ended queue of DEPTH words held in a row of cells, cell 0 being
// the head. Each input item carries one operation and returns one result with a
// status, the match position and the occupancy after the operation. An item is
// taken in the idle state. Pushes, pops, clear and unused codes wait in the execute
// state for a free output register; there every cell shifts, loads or holds and the
// result is registered. A search steps through the search state once per live entry
// (none when empty) and registers its result in the done state once the output
// register is free. The live entries rotate once through the chain, one entry past
// the head cell per cycle, where it is compared, which also leaves the queue in its
// original order. One item is worked on at a time; a finished result waits in an
// output register while the next item is taken. The store needs no clearing pass
// after reset, since entries beyond the occupancy are never read.
module deque_with_value_search_core #(
  parameter int unsigned DEPTH      = dqvs_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dqvs_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  dqvs_item_if.sink     item_i,
  dqvs_result_if.source result_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_W = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] word;
  logic [CNT_W-1:0]      count;
  dqvs_pkg::cell_cmd_e   cmd;

  // Sequencer.
  dqvs_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W),
    .POS_W      (POS_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .result_o    (result_o),
    .head_data_i (cell_data[0]),
    .word_o      (word),
    .count_o     (count),
    .cmd_o       (cmd)
  );

  // Chain of cells; the ends take the pushed word and the head word.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = word;
    end else begin : g_inner_left
      assign left = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right = cell_data[0];
    end else begin : g_inner_right
      assign right = cell_data[g+1];
    end

    dqvs_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count),
      .word_i  (word),
      .left_i  (left),
      .right_i (right),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the deque with value search core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dqvs_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned DATA_WIDTH = DATA_WIDTH_DEF;
  localparam int unsigned POS_W      = $clog2(DEPTH);
  localparam int unsigned OCC_W      = $clog2(DEPTH + 1);

  // Operation codes outside the enum; the block treats them as no operation.
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // A full-queue search walks all DEPTH entries with no transfer at all.
  localparam int unsigned WATCHDOG_LIMIT = 4 * (DEPTH + 16) + 256;
  localparam int unsigned BACKPRESSURE_CYCLES = 64;
  localparam int unsigned MAX_REPORTS = 30;
  localparam int unsigned RANDOM_SEGMENTS = 11;
  localparam int unsigned SEGMENT_ITEMS = 50;

  typedef struct {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  logic clk;
  logic rst_n;

  dqvs_item_if #(.DATA_WIDTH(DATA_WIDTH)) item_ch ();
  dqvs_result_if #(.DEPTH(DEPTH)) result_ch ();

  deque_with_value_search_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_ch),
    .result_o (result_ch)
  );

  // Predicted queue contents, head first, and the results still owed by the block.
  logic [DATA_WIDTH-1:0] deque_contents[$];
  deque_result_t         pending_results[$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned deepest_fill = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  bit          send_no_idle = 1'b0;
  bit          recv_no_idle = 1'b0;

  // Clock generation.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  // Index from the head of the first entry equal to word, or -1 when absent.
  function automatic int position_of(input logic [DATA_WIDTH-1:0] word);
    for (int i = 0; i < deque_contents.size(); i++) begin
      if (deque_contents[i] == word) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one operation to the predicted queue and return the result it owes.
  function automatic deque_result_t predict_deque_op(input logic [OP_W-1:0] op,
                                                     input logic [DATA_WIDTH-1:0] word);
    deque_result_t r;
    int            hit;
    r.status   = ST_OK;
    r.position = '0;
    case (op)
      OP_PUSH_TAIL: begin
        if (deque_contents.size() >= DEPTH) r.status = ST_FULL;
        else deque_contents.push_back(word);
      end
      OP_PUSH_HEAD: begin
        if (deque_contents.size() >= DEPTH) r.status = ST_FULL;
        else deque_contents.push_front(word);
      end
      OP_POP_TAIL: begin
        if (deque_contents.size() == 0) r.status = ST_EMPTY;
        else void'(deque_contents.pop_back());
      end
      OP_POP_HEAD: begin
        if (deque_contents.size() == 0) r.status = ST_EMPTY;
        else void'(deque_contents.pop_front());
      end
      OP_SEARCH: begin
        hit = position_of(word);
        if (hit < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.position = POS_W'(hit);
        end
      end
      OP_CLEAR: begin
        deque_contents.delete();
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(deque_contents.size());
    if (deque_contents.size() > deepest_fill) deepest_fill = deque_contents.size();
    return r;
  endfunction

  // Offer one item after a random gap and record its expected result on transfer.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_WIDTH-1:0] word);
    int gap;
    gap = send_no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid     = 1'b1;
    item_ch.operation = op;
    item_ch.value     = word;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    pending_results.push_back(predict_deque_op(op, word));
    items_sent++;
  endtask

  // Drop valid after the last transfer and wait until every result is back.
  task automatic wait_for_results();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Compare one result transfer with the oldest prediction.
  task automatic check_result(input logic [STATUS_W-1:0] st, input logic [POS_W-1:0] pos,
                              input logic [OCC_W-1:0] occ);
    deque_result_t want;
    results_checked++;
    if (pending_results.size() == 0) begin
      report_error($sformatf("result with none expected: status %0d position %0d occupancy %0d",
                             st, pos, occ));
      return;
    end
    want = pending_results.pop_front();
    if (st !== want.status) begin
      report_error($sformatf("status %0d, expected %s", st, want.status.name()));
    end
    if (pos !== want.position) begin
      report_error($sformatf("position %0d, expected %0d", pos, want.position));
    end
    if (occ !== want.occupancy) begin
      report_error($sformatf("occupancy %0d, expected %0d", occ, want.occupancy));
    end
  endtask

  // Result side: random ready gaps, plus a long hold-off when the pressure test asks.
  initial begin : result_sink
    int gap;
    int held;
    result_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = recv_no_idle ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (hold_request > 0) begin
        held = hold_request;
        hold_request = 0;
        result_ch.ready = 1'b0;
        repeat (held) @(negedge clk);
      end
      if (gap > 0) begin
        result_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      check_result(result_ch.status, result_ch.position, result_ch.occupancy);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Empty-queue errors, unused codes, pushes at the head, duplicates and clear.
  task automatic test_directed();
    send_item(OP_POP_TAIL, 32'h0000_0000);
    send_item(OP_POP_HEAD, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_UNUSED_6, 32'hFFFF_FFFF);
    send_item(OP_UNUSED_7, 32'h0000_0000);
    send_item(OP_PUSH_TAIL, 32'h0000_0000);
    send_item(OP_PUSH_TAIL, 32'hFFFF_FFFF);
    send_item(OP_PUSH_HEAD, 32'hA5A5_5A5A);
    send_item(OP_PUSH_HEAD, 32'h5A5A_A5A5);
    send_item(OP_PUSH_TAIL, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'h5A5A_A5A5);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h1234_5678);
    send_item(OP_POP_HEAD, 32'h0000_0000);
    send_item(OP_POP_TAIL, 32'h0000_0000);
    send_item(OP_UNUSED_7, 32'hFFFF_FFFF);
    send_item(OP_SEARCH, 32'hFFFF_FFFF);
    send_item(OP_CLEAR, 32'h0000_0000);
    send_item(OP_SEARCH, 32'h0000_0000);
    send_item(OP_PUSH_TAIL, 32'h8000_0001);
    send_item(OP_POP_HEAD, 32'h0000_0000);
    send_item(OP_POP_HEAD, 32'h0000_0000);
    send_item(OP_PUSH_HEAD, 32'h7FFF_FFFE);
    send_item(OP_SEARCH, 32'h7FFF_FFFE);
  endtask

  // The result side holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    send_no_idle = 1'b1;
    hold_request = BACKPRESSURE_CYCLES;
    for (int n = 0; n < 12; n++) begin
      if (n % 4 == 3) send_item(OP_SEARCH, deque_contents[0]);
      else send_item((n % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL, $urandom);
    end
    send_no_idle = 1'b0;
  endtask

  // Fill to capacity, push when full, search both ends and a miss, refill, clear, pop.
  task automatic test_full_queue();
    logic [DATA_WIDTH-1:0] word;
    send_item(OP_CLEAR, $urandom);
    send_no_idle = 1'b1;
    for (int n = 0; n < DEPTH; n++) begin
      word = $urandom;
      word[POS_W-1:0] = n[POS_W-1:0];
      send_item((n % 2) ? OP_PUSH_HEAD : OP_PUSH_TAIL, word);
    end
    send_no_idle = 1'b0;
    send_item(OP_PUSH_TAIL, $urandom);
    send_item(OP_PUSH_HEAD, $urandom);
    send_item(OP_SEARCH, deque_contents[deque_contents.size() - 1]);
    send_item(OP_SEARCH, deque_contents[0]);
    word = $urandom;
    while (position_of(word) >= 0) word = $urandom;
    send_item(OP_SEARCH, word);
    send_item(OP_POP_HEAD, $urandom);
    send_item(OP_POP_TAIL, $urandom);
    send_item(OP_PUSH_HEAD, $urandom);
    send_item(OP_PUSH_TAIL, $urandom);
    send_item(OP_PUSH_TAIL, $urandom);
    send_item(OP_SEARCH, deque_contents[deque_contents.size() - 1]);
    send_item(OP_CLEAR, $urandom);
    send_item(OP_POP_TAIL, $urandom);
  endtask

  // Push values: fully random words mixed with small pools that produce duplicates.
  function automatic logic [DATA_WIDTH-1:0] pick_push_value();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 7);
      default: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
    endcase
  endfunction

  // Search values mostly hit a live entry; the rest are random and mostly miss.
  function automatic logic [DATA_WIDTH-1:0] pick_search_value();
    if (deque_contents.size() > 0 && $urandom_range(0, 9) < 7) begin
      return deque_contents[$urandom_range(0, deque_contents.size() - 1)];
    end
    return pick_push_value();
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int push_pct, input int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) return $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
    if (r < push_pct + pop_pct) return $urandom_range(0, 1) ? OP_POP_HEAD : OP_POP_TAIL;
    if (r < 97) return OP_SEARCH;
    if (r < 98) return OP_CLEAR;
    return $urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  // Segments that grow, hold and shrink the queue, under four idle patterns in turn.
  task automatic test_random();
    logic [OP_W-1:0] op;
    int              push_pct;
    int              pop_pct;
    for (int s = 0; s < RANDOM_SEGMENTS; s++) begin
      case (s % 3)
        0:       begin push_pct = 55; pop_pct = 25; end
        1:       begin push_pct = 40; pop_pct = 40; end
        default: begin push_pct = 25; pop_pct = 55; end
      endcase
      send_no_idle = (s % 4 == 1) || (s % 4 == 3);
      recv_no_idle = (s % 4 == 2) || (s % 4 == 3);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        op = pick_op(push_pct, pop_pct);
        send_item(op, (op == OP_SEARCH) ? pick_search_value() : pick_push_value());
      end
    end
    send_no_idle = 1'b0;
    recv_no_idle = 1'b0;
  endtask

  // Test sequence.
  initial begin
    rst_n = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.operation = OP_PUSH_TAIL;
    item_ch.value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_backpressure();
    test_full_queue();
    test_random();

    wait_for_results();
    repeat (16) @(posedge clk);

    $display("Run covered %0d operations and %0d results; the queue reached %0d of %0d entries.",
             items_sent, results_checked, deepest_fill, DEPTH);
    $display("Included empty pops, full pushes, search hits and misses, clear and unused codes.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
